// File: src/ddc_pkg.sv
// ----------------------------------------------------------------------------
// ddc_pkg
// Shared types, constants and the quarter-wave sine table of the down converter
// ----------------------------------------------------------------------------
package ddc_pkg;

  localparam int TAPS           = 127;
  localparam int TAP_AW         = $clog2(TAPS);
  localparam int MAX_DECIMATION = 1024;
  localparam int SINE_BITS      = 10;
  localparam int QUARTER        = 1 << (SINE_BITS - 2);
  localparam int COEF_WIDTH     = 18;
  localparam int PROD_W         = COEF_WIDTH + 16;
  localparam int ACC_W          = PROD_W + TAP_AW + 1;
  localparam int OUT_SHIFT      = COEF_WIDTH - 9;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_LOAD     = 2'd1,
    OP_RESTART  = 2'd2,
    OP_RESERVED = 2'd3
  } opcode_t;

  typedef enum logic {
    CFG_PHASE_INC  = 1'b0,
    CFG_DECIMATION = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MIX,
    S_FIR,
    S_DRAIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic mul;
    logic mix_wr;
    logic issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_tap;
    logic busy;
    logic emit;
    logic out_free;
  } sts_t;

  typedef logic signed [15:0] quad_t [0:QUARTER];

  function automatic quad_t build_quad();
    quad_t  q;
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint r;
    for (int j = 0; j <= QUARTER; j++) begin
      x    = (HALF_PI_Q30 * longint'(j)) / QUARTER;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >>> 30) / TAYLOR_DIV[n-1];
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      if (sum < 0) sum = 0;
      r = (sum + 16384) >>> 15;
      if (r > 32767) r = 32767;
      q[j] = 16'(r);
    end
    return q;
  endfunction

  localparam quad_t SINE_QUAD = build_quad();

  function automatic logic signed [15:0] sine_at(input logic [SINE_BITS-1:0] k);
    logic [1:0]           quad;
    logic [SINE_BITS-2:0] idx;
    logic signed [15:0]   v;
    quad = k[SINE_BITS-1:SINE_BITS-2];
    idx  = quad[0] ? ((SINE_BITS-1)'(QUARTER) - {1'b0, k[SINE_BITS-3:0]})
                   : {1'b0, k[SINE_BITS-3:0]};
    v    = SINE_QUAD[idx];
    return quad[1] ? -v : v;
  endfunction

endpackage

// File: src/digital_down_converter.sv
// ----------------------------------------------------------------------------
// digital_down_converter
// NCO mixer, complex FIR over a circular delay line, and decimator
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    in_opcode, in_sample_i/q, in_coef_*
// out      output     out_valid/out_ready  out_i, out_q
// cfg      input      cfg_we               cfg_index, cfg_data
//
// a sample beat runs accept, multiply, mix and delay line write, a tap sweep with
// one delay line and tap memory read per cycle through the single MAC pipeline,
// drain, and a result load when the decimator emits; load, restart and unknown
// opcodes finish on acceptance without leaving idle
// synchronous active-low reset clears state; taps and delay line read as zero
// a finished result waits in the output register while the next beat runs;
// only its own load stalls on out_ready
// ----------------------------------------------------------------------------
module digital_down_converter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_opcode,
  input  logic signed [15:0]                    in_sample_i,
  input  logic signed [15:0]                    in_sample_q,
  input  logic [6:0]                            in_coef_index,
  input  logic signed [ddc_pkg::COEF_WIDTH-1:0] in_coef_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [23:0]                    out_i,
  output logic signed [23:0]                    out_q,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [31:0]                           cfg_data
);
  import ddc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ddc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  ddc_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_opcode     (in_opcode),
    .in_sample_i   (in_sample_i),
    .in_sample_q   (in_sample_q),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_i         (out_i),
    .out_q         (out_q)
  );

endmodule

// File: src/ddc_ctrl.sv
// ----------------------------------------------------------------------------
// ddc_ctrl
// Sequencer: accept, mix, delay line write, tap sweep, drain and result load
// ----------------------------------------------------------------------------
module ddc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_opcode,
  input  ddc_pkg::sts_t sts,
  output ddc_pkg::cmd_t cmd
);
  import ddc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && in_opcode == OP_SAMPLE) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.mix_wr = 1'b1;
        state_nxt  = S_FIR;
      end
      S_FIR: begin
        cmd.issue = 1'b1;
        if (sts.last_tap) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.busy) state_nxt = sts.emit ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free) else $error("result loaded over a pending beat");
  a_mix_then_fir: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MIX |=> state_r == S_FIR) else $error("tap sweep did not follow mix");
  a_last_tap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIR && sts.last_tap) |=> state_r == S_DRAIN)
    else $error("tap sweep overran");

endmodule

// File: src/ddc_dpath.sv
// ----------------------------------------------------------------------------
// ddc_dpath
// NCO mixer, delay line and tap memories, MAC pipeline and result register
// ----------------------------------------------------------------------------
module ddc_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ddc_pkg::cmd_t                        cmd,
  output ddc_pkg::sts_t                        sts,
  input  logic [1:0]                           in_opcode,
  input  logic signed [15:0]                   in_sample_i,
  input  logic signed [15:0]                   in_sample_q,
  input  logic [6:0]                           in_coef_index,
  input  logic signed [ddc_pkg::COEF_WIDTH-1:0] in_coef_value,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [31:0]                          cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [23:0]                   out_i,
  output logic signed [23:0]                   out_q
);
  import ddc_pkg::*;

  logic [31:0]        phase_inc_r;
  logic [10:0]        dec_r;
  logic [31:0]        phase_r;
  logic [9:0]         count_r;
  logic [TAP_AW-1:0]  wp_r, rp_r, tap_r;
  logic [TAPS-1:0]    dl_vld_r, cf_vld_r;
  logic               emit_r, v1_r, v2_r, out_valid_r;
  logic signed [15:0] si_r, sq_r, sin_r, cos_r;
  logic signed [31:0] pic_r, pqs_r, pis_r, pqc_r;
  logic [31:0]        rd_d_r;
  logic signed [COEF_WIDTH-1:0] rd_c_r;
  logic               rd_dv_r, rd_cv_r;
  logic signed [PROD_W-1:0] pi_r, pq_r;
  logic signed [ACC_W-1:0]  acc_i_r, acc_q_r;
  logic signed [23:0] out_i_r, out_q_r;

  logic [31:0]             dl_mem [TAPS];
  logic [COEF_WIDTH-1:0]   cf_mem [TAPS];

  logic signed [15:0]  mi, mq, di, dq;
  logic signed [COEF_WIDTH-1:0] cv;
  logic [TAP_AW-1:0]   wp_inc;
  logic [10:0]         eff, cnt_next;
  logic                emit_now;

  function automatic logic signed [15:0] mix_round(input logic signed [32:0] v);
    logic signed [32:0] t;
    t = (v + 33'sd16384) >>> 15;
    if (t > 33'sd32767) return 16'sd32767;
    if (t < -33'sd32768) return -16'sd32768;
    return t[15:0];
  endfunction

  function automatic logic signed [23:0] out_round(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    t = (a + (ACC_W'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (t > ACC_W'(24'sh7fffff)) return 24'sh7fffff;
    if (t < -(ACC_W'(24'sh7fffff)) - ACC_W'(1)) return -24'sh7fffff - 24'sd1;
    return t[23:0];
  endfunction

  assign mi = mix_round({pic_r[31], pic_r} - {pqs_r[31], pqs_r});
  assign mq = mix_round({pis_r[31], pis_r} + {pqc_r[31], pqc_r});
  assign wp_inc = (wp_r == TAP_AW'(TAPS - 1)) ? '0 : wp_r + 1'b1;

  always_comb begin
    if (dec_r == '0) eff = 11'd1;
    else if (dec_r > 11'(MAX_DECIMATION)) eff = 11'(MAX_DECIMATION);
    else eff = dec_r;
  end
  assign cnt_next = {1'b0, count_r} + 11'd1;
  assign emit_now = !(cnt_next < eff);

  assign di = rd_dv_r ? $signed(rd_d_r[31:16]) : 16'sd0;
  assign dq = rd_dv_r ? $signed(rd_d_r[15:0]) : 16'sd0;
  assign cv = rd_cv_r ? rd_c_r : '0;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      dec_r       <= 11'd1;
      phase_r     <= '0;
      count_r     <= '0;
      wp_r        <= '0;
      dl_vld_r    <= '0;
      cf_vld_r    <= '0;
      emit_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PHASE_INC:  phase_inc_r <= cfg_data;
          CFG_DECIMATION: dec_r       <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (cmd.take) begin
        case (in_opcode)
          OP_SAMPLE: phase_r <= phase_r + phase_inc_r;
          OP_LOAD: begin
            if (in_coef_index < 7'(TAPS)) cf_vld_r[in_coef_index[TAP_AW-1:0]] <= 1'b1;
          end
          OP_RESTART: begin
            phase_r  <= '0;
            count_r  <= '0;
            wp_r     <= '0;
            dl_vld_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.mix_wr) begin
        dl_vld_r[wp_r] <= 1'b1;
        wp_r           <= wp_inc;
        emit_r         <= emit_now;
        count_r        <= emit_now ? '0 : cnt_next[9:0];
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.take && in_opcode == OP_LOAD && in_coef_index < 7'(TAPS))
      cf_mem[in_coef_index[TAP_AW-1:0]] <= in_coef_value;
    if (cmd.mix_wr) dl_mem[wp_r] <= {mi, mq};
    if (cmd.issue) begin
      rd_d_r <= dl_mem[rp_r];
      rd_c_r <= cf_mem[tap_r];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      si_r  <= in_sample_i;
      sq_r  <= in_sample_q;
      sin_r <= sine_at(phase_r[31 -: SINE_BITS]);
      cos_r <= sine_at(phase_r[31 -: SINE_BITS] + SINE_BITS'(QUARTER));
    end
    if (cmd.mul) begin
      pic_r <= si_r * cos_r;
      pqs_r <= sq_r * sin_r;
      pis_r <= si_r * sin_r;
      pqc_r <= sq_r * cos_r;
    end
    if (cmd.mix_wr) begin
      rp_r    <= wp_inc;
      tap_r   <= '0;
      acc_i_r <= '0;
      acc_q_r <= '0;
    end
    if (cmd.issue) begin
      rd_dv_r <= dl_vld_r[rp_r];
      rd_cv_r <= cf_vld_r[tap_r];
      rp_r    <= (rp_r == TAP_AW'(TAPS - 1)) ? '0 : rp_r + 1'b1;
      tap_r   <= tap_r + 1'b1;
    end
    pi_r <= cv * di;
    pq_r <= cv * dq;
    if (v2_r) begin
      acc_i_r <= acc_i_r + ACC_W'(pi_r);
      acc_q_r <= acc_q_r + ACC_W'(pq_r);
    end
    if (cmd.out_load) begin
      out_i_r <= out_round(acc_i_r);
      out_q_r <= out_round(acc_q_r);
    end
  end

  assign sts.last_tap = (tap_r == TAP_AW'(TAPS - 1));
  assign sts.busy     = v1_r | v2_r;
  assign sts.emit     = emit_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_i     = out_i_r;
  assign out_q     = out_q_r;

endmodule
